@@ sv/fpc_pkg.sv @@
// package for the per-flow packet counter: types, codes and constants
`default_nettype none
package fpc_pkg;

   localparam int unsigned TABLE_ENTRIES_DEF  = 1024;
   localparam int unsigned MINUTE_SECONDS_DEF = 60;

   localparam logic [7:0]  PROTO_TCP = 8'd6;
   localparam logic [7:0]  PROTO_UDP = 8'd17;
   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   // result status codes
   localparam logic [2:0] ST_COUNTED = 3'd0;
   localparam logic [2:0] ST_NEW     = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_RANGE   = 3'd3;
   localparam logic [2:0] ST_READ    = 3'd4;
   localparam logic [2:0] ST_EMPTY   = 3'd5;

   // flow five-tuple
   typedef struct packed {
      logic [31:0] src;
      logic [31:0] dst;
      logic [7:0]  proto;
      logic [15:0] sport;
      logic [15:0] dport;
   } flow_key_type;

   // result transaction payload
   typedef struct packed {
      logic [2:0]   status;
      logic [5:0]   epoch;
      flow_key_type key;
      logic [31:0]  count;
      logic [31:0]  seen;
   } result_type;

   // divider handshake
   typedef struct packed {
      logic start;
      logic [5:0] divisor;
   } div_ctl_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_DIV,
      S_LIMIT,
      S_SEARCH,
      S_COMPARE,
      S_RD_ENTRY,
      S_RD_WAIT,
      S_EMIT
   } fpc_state_type;

endpackage
`default_nettype wire

@@ sv/fpc_req_if.sv @@
// request channel interface: packet or read transaction
`default_nettype none
interface fpc_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [31:0] time_seconds;
   logic [31:0] source_address;
   logic [31:0] destination_address;
   logic [7:0]  protocol_number;
   logic [15:0] source_port;
   logic [15:0] destination_port;
   logic [9:0]  entry_index;

   modport source (output valid, action, time_seconds, source_address,
                   destination_address, protocol_number, source_port,
                   destination_port, entry_index, input ready);
   modport sink   (input valid, action, time_seconds, source_address,
                   destination_address, protocol_number, source_port,
                   destination_port, entry_index, output ready);
endinterface
`default_nettype wire

@@ sv/fpc_rsp_if.sv @@
// response channel interface: one result per transaction
`default_nettype none
interface fpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [5:0]  epoch_out;
   logic [31:0] source_out;
   logic [31:0] destination_out;
   logic [7:0]  protocol_out;
   logic [15:0] source_port_out;
   logic [15:0] destination_port_out;
   logic [31:0] flow_count;
   logic [31:0] packets_seen;

   modport source (output valid, status, epoch_out, source_out, destination_out,
                   protocol_out, source_port_out, destination_port_out,
                   flow_count, packets_seen, input ready);
   modport sink   (input valid, status, epoch_out, source_out, destination_out,
                   protocol_out, source_port_out, destination_port_out,
                   flow_count, packets_seen, output ready);
endinterface
`default_nettype wire

@@ sv/fpc_epoch_div.sv @@
// restoring divider: elapsed seconds divided by the sampling period
`default_nettype none
module fpc_epoch_div #(
   parameter int unsigned DW = 6
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fpc_pkg::div_ctl_type ctl,
   input  wire logic [DW-1:0]        dividend,
   output logic                      done,
   output logic [DW-1:0]             quotient
);
   import fpc_pkg::*;

   localparam int unsigned CW = $clog2(DW + 1);

   logic [5:0]    rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [5:0]    divisor_ff, divisor_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [6:0]    shifted;
   logic          fits;

   // one quotient bit per cycle
   always_comb begin
      shifted    = {rem_ff, quo_ff[DW-1]};
      fits       = shifted >= {1'b0, divisor_ff};
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (ctl.start) begin
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = ctl.divisor;
         cnt_in     = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? 6'(shifted - {1'b0, divisor_ff}) : shifted[5:0];
         quo_in = (quo_ff << 1) | DW'(fits);
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

@@ sv/flow_packet_counter_by_epoch_top.sv @@
// per-flow packet counter by time epoch, top level with the entry memory
//
//  channel   | dir | handshake          | carries
//  ----------+-----+--------------------+------------------------------------
//  req_chan  | in  | valid/ready        | action, timestamp, five-tuple, index
//  rsp_chan  | out | valid/ready        | status, entry fields, packet total
//  csr_*     | in  | write enable       | epoch period in seconds
//
// packet: check, divide, limit, search and compare per entry scanned, emit;
// a time outside the minute emits after check, an epoch past the last after
// limit; read transaction: read, wait, emit, with no wait for an unused index
// one transaction in flight; the result register lets a new transaction in
// while a result waits, a full result register holds the sequencer
// synchronous active-high reset; the entry memory is not cleared
`default_nettype none
module flow_packet_counter_by_epoch_top #(
   parameter int unsigned TABLE_ENTRIES  = fpc_pkg::TABLE_ENTRIES_DEF,
   parameter int unsigned MINUTE_SECONDS = fpc_pkg::MINUTE_SECONDS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   fpc_req_if.sink         req_chan,
   fpc_rsp_if.source       rsp_chan,
   input  wire logic       csr_wr_en,
   input  wire logic [5:0] csr_wr_data
);
   import fpc_pkg::*;

   localparam int unsigned IW = $clog2(TABLE_ENTRIES);
   localparam int unsigned UW = $clog2(TABLE_ENTRIES + 1);
   localparam int unsigned DW = $clog2(MINUTE_SECONDS + 1);
   localparam int unsigned EW = DW;
   localparam int unsigned PW = EW + 7;
   localparam int unsigned MW = EW + $bits(flow_key_type) + 32;

   fpc_state_type state_ff, state_in;
   logic [5:0]    period_ff, period_in;
   logic          start_known_ff, start_known_in;
   logic [31:0]   epoch_base_ff, epoch_base_in;
   logic [31:0]   total_ff, total_in;
   logic [UW-1:0] used_ff, used_in;
   flow_key_type  key_ff, key_in;
   logic [31:0]   time_ff, time_in;
   logic [EW-1:0] epoch_ff, epoch_in;
   logic [UW-1:0] idx_ff, idx_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic          read_hit_ff, read_hit_in;
   result_type    res_ff, res_in;
   result_type    rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [MW-1:0] mem [TABLE_ENTRIES];
   logic [MW-1:0] rd_data_ff;
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] wr_addr;
   logic [MW-1:0] wr_data;
   logic          mem_we;

   div_ctl_type   div_ctl;
   logic          div_done;
   logic [DW-1:0] div_quo;
   logic [5:0]    period_eff;
   logic [31:0]   elapsed;
   logic [PW-1:0] span;
   flow_key_type  pkt_key;
   flow_key_type  ent_key;
   logic [EW-1:0] ent_epoch;
   logic [31:0]   ent_count;
   logic [31:0]   bumped;
   logic          slot_free;

   fpc_epoch_div #(.DW(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (elapsed[DW-1:0]),
      .done     (div_done),
      .quotient (div_quo)
   );

   // entry memory, one read and one write port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign {ent_epoch, ent_key, ent_count} = rd_data_ff;

   // incoming key with ports cleared unless tcp or udp
   always_comb begin
      pkt_key.src   = req_chan.source_address;
      pkt_key.dst   = req_chan.destination_address;
      pkt_key.proto = req_chan.protocol_number;
      if (req_chan.protocol_number == PROTO_TCP || req_chan.protocol_number == PROTO_UDP) begin
         pkt_key.sport = req_chan.source_port;
         pkt_key.dport = req_chan.destination_port;
      end else begin
         pkt_key.sport = '0;
         pkt_key.dport = '0;
      end
   end

   assign period_eff = (period_ff == '0) ? 6'd1 : period_ff;
   assign elapsed    = time_ff - epoch_base_ff;
   assign span       = (PW'(epoch_ff) + PW'(1)) * PW'(period_eff);
   assign bumped     = (ent_count == COUNT_MAX) ? ent_count : ent_count + 32'd1;
   assign slot_free  = !rsp_valid_ff || rsp_chan.ready;

   // sequencer: next state and datapath updates
   always_comb begin
      state_in       = state_ff;
      period_in      = csr_wr_en ? csr_wr_data : period_ff;
      start_known_in = start_known_ff;
      epoch_base_in  = epoch_base_ff;
      total_in       = total_ff;
      used_in        = used_ff;
      key_in         = key_ff;
      time_in        = time_ff;
      epoch_in       = epoch_ff;
      idx_in         = idx_ff;
      rd_idx_in      = rd_idx_ff;
      read_hit_in    = read_hit_ff;
      res_in         = res_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      mem_we         = 1'b0;
      wr_addr        = idx_ff[IW-1:0];
      wr_data        = {epoch_ff, key_ff, 32'd1};
      rd_addr        = idx_ff[IW-1:0];
      div_ctl.start   = 1'b0;
      div_ctl.divisor = period_eff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.action) begin
                  read_hit_in = 32'(req_chan.entry_index) < 32'(used_ff);
                  rd_idx_in   = IW'(req_chan.entry_index);
                  state_in    = S_RD_ENTRY;
               end else begin
                  if (total_ff != COUNT_MAX) begin
                     total_in = total_ff + 32'd1;
                  end
                  if (!start_known_ff) begin
                     start_known_in = 1'b1;
                     epoch_base_in  = req_chan.time_seconds;
                  end
                  key_in   = pkt_key;
                  time_in  = req_chan.time_seconds;
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            res_in.key   = key_ff;
            res_in.epoch = '0;
            res_in.count = '0;
            if (time_ff < epoch_base_ff || elapsed >= 32'(MINUTE_SECONDS)) begin
               res_in.status = ST_RANGE;
               state_in      = S_EMIT;
            end else begin
               div_ctl.start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               epoch_in = div_quo;
               state_in = S_LIMIT;
            end
         end
         S_LIMIT: begin
            if (span > PW'(MINUTE_SECONDS)) begin
               res_in.status = ST_RANGE;
               state_in      = S_EMIT;
            end else begin
               idx_in   = '0;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            res_in.epoch = 6'(epoch_ff);
            if (idx_ff == used_ff) begin
               if (used_ff >= UW'(TABLE_ENTRIES)) begin
                  res_in.status = ST_FULL;
                  res_in.count  = '0;
               end else begin
                  mem_we        = 1'b1;
                  used_in       = used_ff + 1'b1;
                  res_in.status = ST_NEW;
                  res_in.count  = 32'd1;
               end
               state_in = S_EMIT;
            end else begin
               state_in = S_COMPARE;
            end
         end
         S_COMPARE: begin
            if (ent_epoch == epoch_ff && ent_key == key_ff) begin
               mem_we        = 1'b1;
               wr_data       = {epoch_ff, key_ff, bumped};
               res_in.status = ST_COUNTED;
               res_in.count  = bumped;
               state_in      = S_EMIT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SEARCH;
            end
         end
         S_RD_ENTRY: begin
            rd_addr = rd_idx_ff;
            if (read_hit_ff) begin
               state_in = S_RD_WAIT;
            end else begin
               res_in.status = ST_EMPTY;
               res_in.epoch  = '0;
               res_in.key    = '0;
               res_in.count  = '0;
               state_in      = S_EMIT;
            end
         end
         S_RD_WAIT: begin
            res_in.status = ST_READ;
            res_in.epoch  = 6'(ent_epoch);
            res_in.key    = ent_key;
            res_in.count  = ent_count;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_in       = res_ff;
               rsp_in.seen  = total_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         period_ff      <= 6'd1;
         start_known_ff <= 1'b0;
         epoch_base_ff  <= '0;
         total_ff       <= '0;
         used_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         period_ff      <= period_in;
         start_known_ff <= start_known_in;
         epoch_base_ff  <= epoch_base_in;
         total_ff       <= total_in;
         used_ff        <= used_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      key_ff      <= key_in;
      time_ff     <= time_in;
      epoch_ff    <= epoch_in;
      idx_ff      <= idx_in;
      rd_idx_ff   <= rd_idx_in;
      read_hit_ff <= read_hit_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   // channel outputs
   assign req_chan.ready                = (state_ff == S_IDLE);
   assign rsp_chan.valid                = rsp_valid_ff;
   assign rsp_chan.status               = rsp_ff.status;
   assign rsp_chan.epoch_out            = rsp_ff.epoch;
   assign rsp_chan.source_out           = rsp_ff.key.src;
   assign rsp_chan.destination_out      = rsp_ff.key.dst;
   assign rsp_chan.protocol_out         = rsp_ff.key.proto;
   assign rsp_chan.source_port_out      = rsp_ff.key.sport;
   assign rsp_chan.destination_port_out = rsp_ff.key.dport;
   assign rsp_chan.flow_count           = rsp_ff.count;
   assign rsp_chan.packets_seen         = rsp_ff.seen;

endmodule
`default_nettype wire

@@ test/tb_flow_packet_counter_by_epoch_top.sv @@
// testbench for the per-flow packet counter: self-checking with a scoreboard class
`timescale 1ns / 100ps
`default_nettype none
module tb_flow_packet_counter_by_epoch_top;
   import fpc_pkg::*;

   localparam int unsigned TABLE_SIZE  = TABLE_ENTRIES_DEF;
   localparam int unsigned CYCLE_LIMIT = 8000000;
   localparam logic [31:0] T_BASE      = 32'd1000;
   localparam int unsigned KEY_POOL    = 6;

   typedef enum logic {ACT_COUNT = 1'b0, ACT_READ = 1'b1} action_type;

   // one request transaction as the sender sees it
   typedef struct packed {
      action_type   action;
      logic [31:0]  tsec;
      flow_key_type key;
      logic [9:0]   index;
   } packet_req_type;

   // flow table model and expected result store
   class flow_table_scoreboard;
      logic [5:0]   period;
      logic         start_known;
      logic [31:0]  origin;
      logic [31:0]  total;
      int unsigned  used;
      flow_key_type tab_key[TABLE_SIZE];
      logic [5:0]   tab_epoch[TABLE_SIZE];
      logic [31:0]  tab_count[TABLE_SIZE];
      result_type   expected_results[$];
      int unsigned  errors;

      function new();
         period = 6'd1;
         start_known = 1'b0;
         origin = '0;
         total = '0;
         used = 0;
         errors = 0;
      endfunction

      function int unsigned pending();
         return expected_results.size();
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         $display("tb: mismatch on %s: got %h expected %h", what, got, want);
      endtask

      // predict the result of an accepted request
      function void note_request(packet_req_type r);
         result_type   res;
         flow_key_type k;
         int unsigned  eff_period, epochs, ep;
         bit           hit;
         res = '0;
         k = r.key;
         if (r.action == ACT_READ) begin
            if (r.index >= used) begin
               res.status = ST_EMPTY;
            end else begin
               res.status = ST_READ;
               res.epoch = tab_epoch[r.index];
               res.key = tab_key[r.index];
               res.count = tab_count[r.index];
            end
            res.seen = total;
            expected_results.push_back(res);
            return;
         end
         if (total != COUNT_MAX) total++;
         // ports only belong to the key for tcp and udp
         if (k.proto != PROTO_TCP && k.proto != PROTO_UDP) begin
            k.sport = '0;
            k.dport = '0;
         end
         if (!start_known) begin
            start_known = 1'b1;
            origin = r.tsec;
         end
         eff_period = (period == 0) ? 1 : period;
         epochs = MINUTE_SECONDS_DEF / eff_period;
         res.seen = total;
         res.key = k;
         ep = 0;
         if (r.tsec >= origin) ep = (r.tsec - origin) / eff_period;
         if (r.tsec < origin || ep >= epochs) begin
            res.status = ST_RANGE;
            expected_results.push_back(res);
            return;
         end
         res.epoch = ep[5:0];
         hit = 1'b0;
         for (int unsigned i = 0; i < used && !hit; i++) begin
            if (tab_epoch[i] == ep[5:0] && tab_key[i] == k) begin
               if (tab_count[i] != COUNT_MAX) tab_count[i]++;
               res.status = ST_COUNTED;
               res.count = tab_count[i];
               hit = 1'b1;
            end
         end
         if (!hit) begin
            if (used >= TABLE_SIZE) begin
               res.status = ST_FULL;
            end else begin
               tab_key[used] = k;
               tab_epoch[used] = ep[5:0];
               tab_count[used] = 32'd1;
               used++;
               res.status = ST_NEW;
               res.count = 32'd1;
            end
         end
         expected_results.push_back(res);
      endfunction

      // compare an accepted result with the oldest expectation
      task check_result(result_type got);
         result_type want;
         if (expected_results.size() == 0) begin
            report("unexpected result", {29'd0, got.status}, '0);
            return;
         end
         want = expected_results.pop_front();
         if (got.status != want.status) report("status", got.status, want.status);
         if (got.epoch != want.epoch) report("epoch", got.epoch, want.epoch);
         if (got.key.src != want.key.src) report("source", got.key.src, want.key.src);
         if (got.key.dst != want.key.dst) report("destination", got.key.dst, want.key.dst);
         if (got.key.proto != want.key.proto) report("protocol", got.key.proto, want.key.proto);
         if (got.key.sport != want.key.sport) report("source port", got.key.sport, want.key.sport);
         if (got.key.dport != want.key.dport)
            report("destination port", got.key.dport, want.key.dport);
         if (got.count != want.count) report("flow count", got.count, want.count);
         if (got.seen != want.seen) report("packets seen", got.seen, want.seen);
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [5:0] csr_wr_data;
   logic no_idle;
   int unsigned cycle_count;
   flow_table_scoreboard sb;
   flow_key_type key_pool[KEY_POOL];

   fpc_req_if req_chan();
   fpc_rsp_if rsp_chan();

   flow_packet_counter_by_epoch_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // clock
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result side: check accepted transactions, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_result({rsp_chan.status, rsp_chan.epoch_out, rsp_chan.source_out,
                          rsp_chan.destination_out, rsp_chan.protocol_out,
                          rsp_chan.source_port_out, rsp_chan.destination_port_out,
                          rsp_chan.flow_count, rsp_chan.packets_seen});
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= no_idle || ($urandom_range(0, 99) >= 17);
   end

   // drive one request transaction and wait for its acceptance
   task send_request(packet_req_type r);
      while (!no_idle && $urandom_range(0, 99) < 17) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.action <= r.action;
      req_chan.time_seconds <= r.tsec;
      req_chan.source_address <= r.key.src;
      req_chan.destination_address <= r.key.dst;
      req_chan.protocol_number <= r.key.proto;
      req_chan.source_port <= r.key.sport;
      req_chan.destination_port <= r.key.dport;
      req_chan.entry_index <= r.index;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(r);
   endtask

   // write the sampling period once the block has drained
   task write_period(logic [5:0] value);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.period = value;
   endtask

   function automatic packet_req_type make_packet(flow_key_type k, logic [31:0] t);
      packet_req_type r;
      r.action = ACT_COUNT;
      r.tsec = t;
      r.key = k;
      r.index = 10'($urandom);
      return r;
   endfunction

   function automatic packet_req_type make_read(logic [9:0] idx);
      packet_req_type r;
      r.action = ACT_READ;
      r.tsec = $urandom;
      r.key = {$urandom, $urandom, 8'($urandom), 16'($urandom), 16'($urandom)};
      r.index = idx;
      return r;
   endfunction

   function automatic flow_key_type random_key();
      flow_key_type k;
      int unsigned sel;
      sel = $urandom_range(0, 3);
      k.src = $urandom;
      k.dst = $urandom;
      k.proto = (sel == 0) ? PROTO_TCP : (sel == 1) ? PROTO_UDP : 8'($urandom);
      k.sport = 16'($urandom);
      k.dport = 16'($urandom);
      return k;
   endfunction

   // random request: mostly packets on known flows near the start time
   function automatic packet_req_type random_request();
      int unsigned pick;
      flow_key_type k;
      logic [31:0] t;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         if ($urandom_range(0, 3) == 0) return make_read(10'($urandom));
         return make_read(10'($urandom_range(0, sb.used + 3)));
      end
      k = key_pool[$urandom_range(0, KEY_POOL - 1)];
      // non tcp/udp flows with varying ports must still merge
      if (k.proto != PROTO_TCP && k.proto != PROTO_UDP) begin
         k.sport = 16'($urandom);
         k.dport = 16'($urandom);
      end
      if (pick < 20) k = random_key();
      if (pick < 75) t = T_BASE + $urandom_range(0, 11);
      else if (pick < 88) t = T_BASE + $urandom_range(0, 69);
      else if (pick < 94) t = $urandom_range(0, T_BASE - 1);
      else t = $urandom;
      return make_packet(k, t);
   endfunction

   initial begin
      flow_key_type k;
      logic [5:0] periods[10];
      sb = new();
      cycle_count = 0;
      no_idle = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.action = ACT_COUNT;
      req_chan.time_seconds = '0;
      req_chan.source_address = '0;
      req_chan.destination_address = '0;
      req_chan.protocol_number = '0;
      req_chan.source_port = '0;
      req_chan.destination_port = '0;
      req_chan.entry_index = '0;
      rsp_chan.ready = 1'b0;
      periods = '{6'd0, 6'd1, 6'd2, 6'd3, 6'd7, 6'd13, 6'd30, 6'd60, 6'd63, 6'd5};
      for (int i = 0; i < KEY_POOL; i++) key_pool[i] = random_key();
      key_pool[0].proto = PROTO_TCP;
      key_pool[1].proto = PROTO_UDP;
      key_pool[2].proto = 8'd1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: start time, merge, port zeroing, range edges, reads
      write_period(6'd1);
      send_request(make_packet(key_pool[0], T_BASE));
      send_request(make_packet(key_pool[0], T_BASE));
      send_request(make_packet(key_pool[1], T_BASE + 1));
      send_request(make_packet(key_pool[2], T_BASE + 2));
      k = key_pool[2];
      k.sport = ~k.sport;
      send_request(make_packet(k, T_BASE + 2));
      send_request(make_packet(key_pool[0], T_BASE + 59));
      send_request(make_packet(key_pool[0], T_BASE + 60));
      send_request(make_packet(key_pool[1], T_BASE - 1));
      send_request(make_packet(key_pool[1], 32'd0));
      send_request(make_packet(key_pool[1], 32'hFFFF_FFFF));
      send_request(make_packet('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF},
                               T_BASE + 3));
      send_request(make_packet('{32'd0, 32'd0, PROTO_UDP, 16'hFFFF, 16'hFFFF},
                               T_BASE + 4));
      send_request(make_packet('{32'd0, 32'd0, 8'd0, 16'd0, 16'd0}, T_BASE + 4));
      send_request(make_read(10'd0));
      send_request(make_read(10'd3));
      send_request(make_read(10'd5));
      send_request(make_read(10'd1023));
      // zero period acts as one, one epoch per minute, no epochs at all
      write_period(6'd0);
      send_request(make_packet(key_pool[0], T_BASE + 59));
      write_period(6'd60);
      send_request(make_packet(key_pool[3], T_BASE + 59));
      send_request(make_packet(key_pool[3], T_BASE + 60));
      write_period(6'd63);
      send_request(make_packet(key_pool[3], T_BASE));
      send_request(make_read(10'd1));

      // random phases over several periods, one stretch without stalls
      for (int ph = 0; ph < 6; ph++) begin
         write_period(ph == 0 ? 6'd1 : periods[$urandom_range(0, 9)]);
         no_idle = (ph == 2);
         repeat (140) send_request(random_request());
      end
      no_idle = 1'b0;

      // new flows, hits on known flows and reads
      write_period(6'd1);
      repeat (6) send_request(make_packet(random_key(), T_BASE + $urandom_range(0, 59)));
      repeat (6) send_request(make_packet(key_pool[$urandom_range(0, 1)],
                                          T_BASE + $urandom_range(0, 5)));
      send_request(make_read(10'd1023));
      repeat (10) send_request(make_read(10'($urandom)));

      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
`default_nettype wire
